>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked during reset too.
`define ASSERT_CLK_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> src/prle_pkg.sv
package prle_pkg;

  localparam int unsigned ILEN_W = 26;
  localparam int unsigned OLEN_W = 32;

  // decoder phase
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;

  // status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_INPUT_END = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // action codes
  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // configuration register indexes
  localparam logic CFG_INPUT_LENGTH  = 1'b0;
  localparam logic CFG_OUTPUT_LENGTH = 1'b1;

  // no-op header byte (-128)
  localparam logic [7:0] HDR_NOP = 8'h80;

  typedef struct packed {
    logic [1:0]        phase;
    logic [7:0]        literal_left;
    logic [7:0]        repeat_count;
    logic [ILEN_W-1:0] input_position;
    logic [OLEN_W-1:0] output_position;
    logic [2:0]        decode_status;
  } dec_state_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] out_byte;
    logic [7:0] run_length;
    logic [2:0] status;
  } dec_result_t;

  localparam dec_state_t DEC_STATE_CLEAR = '{
    phase:           PH_HEADER,
    literal_left:    8'd0,
    repeat_count:    8'd0,
    input_position:  '0,
    output_position: '0,
    decode_status:   ST_BUSY
  };

endpackage

>>> src/packbits_rle_decoder_core.sv
// PackBits run-length decoder. One compressed byte is taken per item and
// exactly one result comes back per item: a run as a byte value and a copy
// count (1 for each literal byte, 2..128 for a repeat, 0 with no run), plus
// the decoder status. Throughput is one item per clock while results are
// taken. An item is captured in the input register when accepted; the
// combinational decode step fills the result register once it is free. A
// result left waiting holds the input register; the input stays ready in
// that cycle whenever out_ready is high. The user must write the lengths
// via the cfg port (index 0 input length, index 1 output length) only while
// idle, unenforced by the block; a restart clears position counters and status.
module packbits_rle_decoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_write_enable,
  output logic [7:0]                  out_out_byte,
  output logic [7:0]                  out_run_length,
  output logic [2:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data
);

  logic                          s1_valid_r;
  logic                          s1_action_r;
  logic [7:0]                    s1_byte_r;
  logic                          out_valid_r;
  prle_pkg::dec_result_t         out_res_r;
  prle_pkg::dec_state_t          state_r;
  prle_pkg::dec_state_t          state_nxt;
  prle_pkg::dec_result_t         res_nxt;
  logic [prle_pkg::ILEN_W-1:0]   ilen_r;
  logic [prle_pkg::OLEN_W-1:0]   olen_r;
  logic                          advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  prle_step u_step (
    .cur           (state_r),
    .action        (s1_action_r),
    .data_byte     (s1_byte_r),
    .input_length  (ilen_r),
    .output_length (olen_r),
    .nxt           (state_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ilen_r <= '0;
      olen_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prle_pkg::CFG_INPUT_LENGTH:  ilen_r <= cfg_data[prle_pkg::ILEN_W-1:0];
        prle_pkg::CFG_OUTPUT_LENGTH: olen_r <= cfg_data;
        default: ilen_r <= ilen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= prle_pkg::DEC_STATE_CLEAR;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_data_byte;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_res_r.write_enable;
  assign out_out_byte     = out_res_r.out_byte;
  assign out_run_length   = out_res_r.run_length;
  assign out_status       = out_res_r.status;

endmodule

>>> src/prle_step.sv
// One decode step: next state and result for one item.
module prle_step (
  input  prle_pkg::dec_state_t                cur,
  input  logic                                action,
  input  logic [7:0]                          data_byte,
  input  logic [prle_pkg::ILEN_W-1:0]         input_length,
  input  logic [prle_pkg::OLEN_W-1:0]         output_length,
  output prle_pkg::dec_state_t                nxt,
  output prle_pkg::dec_result_t               res
);

  logic [prle_pkg::ILEN_W:0] lit_in_sum;
  logic [prle_pkg::ILEN_W:0] ipos_inc;
  logic [prle_pkg::OLEN_W:0] lit_out_sum;
  logic [prle_pkg::OLEN_W:0] rep_hdr_sum;
  logic [prle_pkg::OLEN_W:0] rep_out_sum;
  logic [prle_pkg::ILEN_W:0] ilen_x;
  logic [prle_pkg::OLEN_W:0] olen_x;
  logic [7:0]                hdr_rep_count;
  logic [7:0]                lit_left_dec;
  prle_pkg::dec_state_t      mid;
  prle_pkg::dec_result_t     res_mid;

  assign ilen_x        = {1'b0, input_length};
  assign olen_x        = {1'b0, output_length};
  assign ipos_inc      = {1'b0, cur.input_position} + (prle_pkg::ILEN_W+1)'(1);
  // literal header: position after header plus run of data_byte+1
  assign lit_in_sum    = {1'b0, cur.input_position} + (prle_pkg::ILEN_W+1)'(data_byte)
                         + (prle_pkg::ILEN_W+1)'(2);
  assign lit_out_sum   = {1'b0, cur.output_position} + (prle_pkg::OLEN_W+1)'(data_byte)
                         + (prle_pkg::OLEN_W+1)'(1);
  // repeat count 1-n, i.e. 257-b, 2..128 for a repeat header
  assign hdr_rep_count = 8'd1 - data_byte;
  assign rep_hdr_sum   = {1'b0, cur.output_position} + (prle_pkg::OLEN_W+1)'(hdr_rep_count);
  assign rep_out_sum   = {1'b0, cur.output_position}
                         + (prle_pkg::OLEN_W+1)'(cur.repeat_count);
  assign lit_left_dec  = cur.literal_left - 8'd1;

  always_comb begin
    mid     = cur;
    res_mid = '0;
    if (action == prle_pkg::ACT_RESTART) begin
      mid = prle_pkg::DEC_STATE_CLEAR;
    end else if (cur.decode_status == prle_pkg::ST_BUSY) begin
      case (cur.phase)
        prle_pkg::PH_HEADER: begin
          if (cur.output_position >= output_length) begin
            mid.decode_status = prle_pkg::ST_FULL;
          end else if (cur.input_position >= input_length) begin
            mid.decode_status = prle_pkg::ST_INPUT_END;
          end else begin
            mid.input_position = ipos_inc[prle_pkg::ILEN_W-1:0];
            if (!data_byte[7]) begin
              if (lit_in_sum > ilen_x) begin
                mid.decode_status = prle_pkg::ST_TRUNC;
              end else if (lit_out_sum > olen_x) begin
                mid.decode_status = prle_pkg::ST_OVERFLOW;
              end else begin
                mid.literal_left = data_byte + 8'd1;
                mid.phase        = prle_pkg::PH_LITERAL;
              end
            end else if (data_byte != prle_pkg::HDR_NOP) begin
              if (ipos_inc >= ilen_x) begin
                mid.decode_status = prle_pkg::ST_TRUNC;
              end else if (rep_hdr_sum > olen_x) begin
                mid.decode_status = prle_pkg::ST_OVERFLOW;
              end else begin
                mid.repeat_count = hdr_rep_count;
                mid.phase        = prle_pkg::PH_REPEAT;
              end
            end
          end
        end
        prle_pkg::PH_LITERAL: begin
          if (cur.input_position >= input_length) begin
            mid.decode_status = prle_pkg::ST_TRUNC;
          end else if (cur.output_position >= output_length) begin
            mid.decode_status = prle_pkg::ST_OVERFLOW;
          end else begin
            mid.input_position  = ipos_inc[prle_pkg::ILEN_W-1:0];
            mid.output_position = cur.output_position + prle_pkg::OLEN_W'(1);
            mid.literal_left    = lit_left_dec;
            if (lit_left_dec == 8'd0) begin
              mid.phase = prle_pkg::PH_HEADER;
            end
            res_mid.write_enable = 1'b1;
            res_mid.out_byte     = data_byte;
            res_mid.run_length   = 8'd1;
          end
        end
        prle_pkg::PH_REPEAT: begin
          if (cur.input_position >= input_length) begin
            mid.decode_status = prle_pkg::ST_TRUNC;
          end else if (rep_out_sum > olen_x) begin
            mid.decode_status = prle_pkg::ST_OVERFLOW;
          end else begin
            mid.input_position   = ipos_inc[prle_pkg::ILEN_W-1:0];
            mid.output_position  = rep_out_sum[prle_pkg::OLEN_W-1:0];
            mid.repeat_count     = 8'd0;
            mid.phase            = prle_pkg::PH_HEADER;
            res_mid.write_enable = 1'b1;
            res_mid.out_byte     = data_byte;
            res_mid.run_length   = cur.repeat_count;
          end
        end
        default: begin
          mid = cur;
        end
      endcase
    end
  end

  // end checks once the step leaves the decoder waiting for a header
  always_comb begin
    nxt = mid;
    if (mid.decode_status == prle_pkg::ST_BUSY && mid.phase == prle_pkg::PH_HEADER) begin
      if (mid.output_position >= output_length) begin
        nxt.decode_status = prle_pkg::ST_FULL;
      end else if (mid.input_position >= input_length) begin
        nxt.decode_status = prle_pkg::ST_INPUT_END;
      end
    end
    res        = res_mid;
    res.status = nxt.decode_status;
  end

endmodule

>>> src/prle_checker.sv
`include "assert_macros.svh"

module prle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_write_enable,
  input logic [7:0] out_out_byte,
  input logic [7:0] out_run_length,
  input logic [2:0] out_status
);

  logic        wr_beat;
  logic        empty_beat;
  logic        run_status_ok;
  logic [19:0] out_fields;

  assign wr_beat       = out_valid && out_write_enable;
  assign empty_beat    = out_valid && !out_write_enable;
  assign out_fields    = {out_write_enable, out_out_byte, out_run_length, out_status};
  assign run_status_ok = out_status == prle_pkg::ST_BUSY || out_status == prle_pkg::ST_FULL
                         || out_status == prle_pkg::ST_INPUT_END;

  // a waiting result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_fields))

  // no result right after reset
  `ASSERT_CLK_NR(a_rst_quiet, clk, !rst_n |=> !out_valid)

  // a written run carries copies; an empty result carries zeros
  `ASSERT_CLK(a_run_len, clk, rst_n, wr_beat |-> out_run_length != 8'd0 && out_run_length <= 8'd128)
  `ASSERT_CLK(a_empty_zero, clk, rst_n, empty_beat |-> {out_out_byte, out_run_length} == 16'd0)

  // a run is only emitted when it fitted, so never with a truncation or overflow status
  `ASSERT_CLK(a_we_status, clk, rst_n, wr_beat |-> run_status_ok)

endmodule

bind packbits_rle_decoder_core prle_checker u_prle_checker (.*);
